// ===== rtl/core/bcc_pkg.sv =====
// bcc_pkg: shared types, register indexes and reset values for the
// button click classifier. no dependencies.

package bcc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS         = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK_MS     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_CLICK_MS       = 2'd3;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_MS_RST     = 16'd50;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_CLICK_MS_RST = 16'd400;
    localparam logic [CFG_WIDTH-1:0] LONG_CLICK_MS_RST   = 16'd1000;

    typedef struct packed {
        logic                 double_click_enable;
        logic [CFG_WIDTH-1:0] debounce_ms;
        logic [CFG_WIDTH-1:0] double_click_ms;
        logic [CFG_WIDTH-1:0] long_click_ms;
    } bcc_cfg_t;

    typedef struct packed {
        logic double_click;
        logic long_click;
        logic short_click;
    } bcc_result_t;

endpackage

// ===== rtl/core/bcc_core.sv =====
// bcc_core: click state registers and the per-tick classification logic.
// depends on bcc_pkg.

module bcc_core import bcc_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic        pressed,
    input  bcc_cfg_t    cfg,
    output bcc_result_t result
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    logic                   holding_reg, holding_next;
    logic [COUNT_WIDTH-1:0] hold_ticks_reg, hold_ticks_next;
    logic                   window_open_reg, window_open_next;
    logic [COUNT_WIDTH-1:0] window_ticks_reg, window_ticks_next;
    logic                   done_mark_reg, done_mark_next;

    logic [COUNT_WIDTH-1:0] hold_inc, window_inc;
    logic [CMP_W-1:0]       debounce_x, dclick_x, long_x;

    assign debounce_x = CMP_W'(cfg.debounce_ms);
    assign dclick_x   = CMP_W'(cfg.double_click_ms);
    assign long_x     = CMP_W'(cfg.long_click_ms);

    // saturating advance of running counters
    assign hold_inc   = (hold_ticks_reg == '1) ? hold_ticks_reg : hold_ticks_reg + 1'b1;
    assign window_inc = (window_ticks_reg == '1) ? window_ticks_reg : window_ticks_reg + 1'b1;

    always_comb begin
        holding_next      = holding_reg;
        hold_ticks_next   = holding_reg ? hold_inc : hold_ticks_reg;
        window_open_next  = window_open_reg;
        window_ticks_next = window_open_reg ? window_inc : window_ticks_reg;
        done_mark_next    = done_mark_reg;
        result            = '0;

        if (pressed) begin
            if (!holding_reg) begin
                holding_next    = 1'b1;
                hold_ticks_next = '0;
                done_mark_next  = 1'b0;
            end
        end else begin
            if (holding_reg) begin
                if (!cfg.double_click_enable) begin
                    if (!done_mark_reg && (CMP_W'(hold_ticks_next) >= debounce_x)) begin
                        result.short_click = 1'b1;
                    end
                end else if (window_open_reg) begin
                    window_open_next    = 1'b0;
                    window_ticks_next   = '0;
                    result.double_click = 1'b1;
                    done_mark_next      = 1'b1;
                end else begin
                    window_open_next  = 1'b1;
                    window_ticks_next = '0;
                end
            end
            holding_next    = 1'b0;
            hold_ticks_next = '0;
        end

        if (!done_mark_next) begin
            if (window_open_next && (CMP_W'(window_ticks_next) >= dclick_x)) begin
                result.short_click = 1'b1;
                window_open_next   = 1'b0;
                window_ticks_next  = '0;
                done_mark_next     = 1'b1;
            end
            // long check still runs when the window expired this tick
            if (holding_next && (CMP_W'(hold_ticks_next) >= long_x)) begin
                result.long_click = 1'b1;
                done_mark_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holding_reg      <= 1'b0;
            hold_ticks_reg   <= '0;
            window_open_reg  <= 1'b0;
            window_ticks_reg <= '0;
            done_mark_reg    <= 1'b0;
        end else if (step_en) begin
            holding_reg      <= holding_next;
            hold_ticks_reg   <= hold_ticks_next;
            window_open_reg  <= window_open_next;
            window_ticks_reg <= window_ticks_next;
            done_mark_reg    <= done_mark_next;
        end
    end

endmodule

// ===== rtl/core/button_click_classifier.sv =====
// button_click_classifier: top level with input register, config registers
// and result register around bcc_core. depends on bcc_pkg and bcc_core.
//
//   channel | direction | tdata (low bit first)
//   s_      | in        | pressed, zero fill
//   m_      | out       | short_click, long_click, double_click, zero fill
//   cfg_    | in        | write enable, 2-bit index, 16-bit data
//
// one tick per cycle sustained while the result is not stalled; ticks go
// through the input register, then are classified into the result register.
// reset is synchronous, active low, and clears state to idle with
// registers at their default thresholds.
// a stalled result holds both stages; the input side keeps taking ticks while
// the input register is empty or the output register is empty or being drained.

module button_click_classifier import bcc_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [0] pressed, [7:1] zero

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [0] short_click, [1] long_click,
                                              // [2] double_click, [7:3] zero

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_wdata
);

    bcc_cfg_t    cfg_reg;
    logic        in_valid_reg;
    logic        in_pressed_reg;
    logic        m_valid_reg;
    bcc_result_t m_result_reg;
    bcc_result_t result;
    logic        advance;
    logic        step_en;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.double_click_enable <= 1'b0;
            cfg_reg.debounce_ms         <= DEBOUNCE_MS_RST;
            cfg_reg.double_click_ms     <= DOUBLE_CLICK_MS_RST;
            cfg_reg.long_click_ms       <= LONG_CLICK_MS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DOUBLE_CLICK_ENABLE: cfg_reg.double_click_enable <= cfg_wdata[0];
                REG_DEBOUNCE_MS:         cfg_reg.debounce_ms         <= cfg_wdata;
                REG_DOUBLE_CLICK_MS:     cfg_reg.double_click_ms     <= cfg_wdata;
                REG_LONG_CLICK_MS:       cfg_reg.long_click_ms       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_pressed_reg <= s_tdata[0];
        end
    end

    bcc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .pressed (in_pressed_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_result_reg.double_click, m_result_reg.long_click,
                       m_result_reg.short_click};

endmodule
